### rtl/astr_pkg.sv
// Shared types and codes for the active set max tracker.
package astr_pkg;

  localparam int unsigned ModeBits   = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned PortBits   = 32;
  localparam int unsigned TagBits    = 16;

  typedef enum logic [ModeBits-1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2,
    ST_RES  = 2'd3
  } state_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;  // register the compare flags against the command value
    logic ins;  // commit an insert
    logic rem;  // commit a remove
  } cell_ctl_t;

endpackage

### rtl/astr_cell.sv
// One slot of the sorted chain: holds a value, compares it, shifts with its neighbors.
module astr_cell
  import astr_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [VALUE_BITS-1:0] cmd_value_i,
  input  logic                         prev_valid_i,
  input  logic signed [VALUE_BITS-1:0] prev_value_i,
  input  logic                         prev_gt_i,
  input  logic                         prev_keep_i,
  input  logic                         next_valid_i,
  input  logic signed [VALUE_BITS-1:0] next_value_i,
  output logic                         valid_o,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic                         gt_o,
  output logic                         keep_o,
  output logic                         match_o
);

  logic                         valid_q, valid_d;
  logic signed [VALUE_BITS-1:0] value_q, value_d;
  logic                         gt_q, eq_q;

  // Flags from the compare step; the chain is sorted largest first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      gt_q <= valid_q && (value_q > cmd_value_i);
      eq_q <= valid_q && (value_q == cmd_value_i);
    end
  end

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        value_d = cmd_value_i;
      end else begin
        valid_d = prev_valid_i;
        value_d = prev_value_i;
      end
    end else if (ctl_i.rem && !gt_q) begin
      // close the gap: pull from the right neighbor
      valid_d = next_valid_i;
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign gt_o    = gt_q;
  assign keep_o  = gt_q | eq_q;
  assign match_o = eq_q && prev_gt_i;

endmodule

### rtl/active_set_max_tracker.sv
// Top level: sequencer, sorted cell chain and result register of the max tracker.
//
// Usage: each input word is one sweep event (insert a value, query the
// maximum, remove one copy of a value). Every event gives exactly one result
// word with a status, the largest value held after the event (zero when
// empty), the echoed tag and a query flag.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// After the input is accepted, the event passes through the compare, update
// and result load steps. One event is in flight at a time, so the block takes
// no new word until the result of the last one is loaded. The compare and
// shift steps belong to the cell chain, which keeps values sorted largest
// first so the maximum sits in the first cell.
// While the receiver stalls, the result register holds its word and the
// sequencer waits in its result step; input stays stalled until it drains.
// Reset empties the chain at once (slot valid bits clear) and drops any
// pending result; the value storage itself is not cleared.
module active_set_max_tracker
  import astr_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ModeBits-1:0]          mode_i,
  input  logic signed [PortBits-1:0]   value_i,
  input  logic [TagBits-1:0]           query_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [StatusBits-1:0]        status_o,
  output logic signed [PortBits-1:0]   max_value_o,
  output logic [TagBits-1:0]           tag_out_o,
  output logic                         was_query_o
);

  state_e                       state_q, state_d;
  logic                         in_accept;
  logic [ModeBits-1:0]          cmd_mode_q;
  logic signed [VALUE_BITS-1:0] cmd_value_q;
  logic signed [VALUE_BITS-1:0] in_value;
  logic [TagBits-1:0]           cmd_tag_q;
  status_e                      status_q, status_d;
  cell_ctl_t                    ctl;
  logic                         out_load;
  logic                         hit;
  logic                         full;

  logic [CAPACITY-1:0]          valid_vec;
  logic [CAPACITY-1:0]          gt_vec;
  logic [CAPACITY-1:0]          keep_vec;
  logic [CAPACITY-1:0]          match_vec;
  logic signed [VALUE_BITS-1:0] value_arr [CAPACITY];
  logic signed [PortBits-1:0]   max_ext;

  logic                         out_valid_q;
  logic [StatusBits-1:0]        out_status_q;
  logic signed [PortBits-1:0]   out_max_q;
  logic [TagBits-1:0]           out_tag_q;
  logic                         out_query_q;

  // Width adaptation between the 32-bit ports and the stored value width.
  if (VALUE_BITS > PortBits) begin : g_wide
    assign in_value = {{(VALUE_BITS-PortBits){value_i[PortBits-1]}}, value_i};
    assign max_ext  = value_arr[0][PortBits-1:0];
  end else if (VALUE_BITS == PortBits) begin : g_same
    assign in_value = value_i;
    assign max_ext  = value_arr[0];
  end else begin : g_narrow
    assign in_value = value_i[VALUE_BITS-1:0];
    assign max_ext  = {{(PortBits-VALUE_BITS){value_arr[0][VALUE_BITS-1]}}, value_arr[0]};
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign hit       = |match_vec;
  assign full      = valid_vec[CAPACITY-1];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_RES;
      ST_RES:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ctl        = '0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_CMP:  ctl.cmp = 1'b1;
      ST_UPD: begin
        ctl.ins = (cmd_mode_q == MODE_INSERT) && !full;
        ctl.rem = (cmd_mode_q == MODE_REMOVE) && hit;
      end
      ST_RES:  out_load = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    status_d = status_q;
    if (state_q == ST_UPD) begin
      status_d = STATUS_OK;
      if (cmd_mode_q == MODE_INSERT && full) begin
        status_d = STATUS_FULL;
      end else if (cmd_mode_q == MODE_REMOVE && !hit) begin
        status_d = STATUS_NOT_FOUND;
      end
    end else if (state_q == ST_RES && cmd_mode_q == MODE_QUERY && !valid_vec[0]) begin
      status_d = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_mode_q  <= mode_i;
      cmd_value_q <= in_value;
      cmd_tag_q   <= query_tag_i;
    end
    status_q <= status_d;
  end

  // Sorted chain, largest value in cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         prev_valid, prev_gt, prev_keep, next_valid;
    logic signed [VALUE_BITS-1:0] prev_value, next_value;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_value = '0;
      assign prev_gt    = 1'b1;
      assign prev_keep  = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
      assign prev_value = value_arr[i-1];
      assign prev_gt    = gt_vec[i-1];
      assign prev_keep  = keep_vec[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_value = '0;
    end else begin : g_link
      assign next_valid = valid_vec[i+1];
      assign next_value = value_arr[i+1];
    end

    astr_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cmd_value_i (cmd_value_q),
      .prev_valid_i(prev_valid),
      .prev_value_i(prev_value),
      .prev_gt_i   (prev_gt),
      .prev_keep_i (prev_keep),
      .next_valid_i(next_valid),
      .next_value_i(next_value),
      .valid_o     (valid_vec[i]),
      .value_o     (value_arr[i]),
      .gt_o        (gt_vec[i]),
      .keep_o      (keep_vec[i]),
      .match_o     (match_vec[i])
    );
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_d;
      out_max_q    <= valid_vec[0] ? max_ext : '0;
      out_tag_q    <= cmd_tag_q;
      out_query_q  <= (cmd_mode_q == MODE_QUERY);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign max_value_o = out_max_q;
  assign tag_out_o   = out_tag_q;
  assign was_query_o = out_query_q;

  // Occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not contiguous");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> $onehot0(match_vec))
    else $error("more than one remove point in the chain");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rem |=> $countones(valid_vec) == $past($countones(valid_vec)) - 1)
    else $error("remove did not drop exactly one value");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("insert did not add exactly one value");

  a_load_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == ST_RES && state_d == ST_IDLE)
    else $error("result loaded outside the result step");

endmodule
